// ===== rtl/nsp_pkg.sv =====
// Shared types, constants and digit decode for the numeric string parser.
package nsp_pkg;

    // Default sizing
    localparam int NSP_MAX_OFFSET = 255;
    localparam int NSP_VALUE_BITS = 32;

    // Fixed port field widths
    localparam int CHAR_W   = 8;
    localparam int BASE_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int OFFSET_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    // Fixed radices
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_SIGN   = 7'b0000010,
        PH_PREFIX = 7'b0000100,
        PH_ZAUTO  = 7'b0001000,
        PH_ZHEX   = 7'b0010000,
        PH_XPEND  = 7'b0100000,
        PH_DIGITS = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [BASE_W-1:0] number_base;
        logic              signed_mode;
    } cfg_t;

    typedef struct packed {
        logic              go;
        logic [CHAR_W-1:0] char_code;
        logic              string_start;
    } step_t;

    typedef struct packed {
        logic                emit;
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_decode(input logic [CHAR_W-1:0] c);
        digit_t d;
        d.hit = 1'b1;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
            d.val = 4'(c - CH_ZERO);
        else if (c >= CH_UP_A && c <= CH_UP_F)
            d.val = 4'(c - CH_UP_A + 8'd10);
        else if (c >= CH_LO_A && c <= CH_LO_F)
            d.val = 4'(c - CH_LO_A + 8'd10);
        else
            d.hit = 1'b0;
        return d;
    endfunction

endpackage

// ===== rtl/nsp_char_if.sv =====
// Character input channel.
interface nsp_char_if
    import nsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              string_start;

    modport source (output valid, output char_code, output string_start, input ready);
    modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

// ===== rtl/nsp_result_if.sv =====
// Parse result output channel.
interface nsp_result_if
    import nsp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  parsed_value;
    logic [OFFSET_W-1:0] end_offset;

    modport source (output valid, output parsed_value, output end_offset, input ready);
    modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

// ===== rtl/nsp_cfg_if.sv =====
// Configuration register write channel.
interface nsp_cfg_if
    import nsp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/numeric_string_parser.sv =====
// Top level of the streaming string-to-integer parser.
//
//  Channel  Role  Moves                                  Transfer when
//  chars    sink  char_code, string_start (one char)     chars.valid & chars.ready
//  results  src   parsed_value, end_offset               results.valid & results.ready
//  regs     sink  index, data (0 number_base, 1 signed)  regs.valid (ready tied high)
//
// One character is taken per cycle while chars.ready is high. A character is
// captured in the input register, then the step logic (prefix/sign chain and
// one multiply-add by the latched radix) updates the parse state and, when the
// parse ends, loads the result register, which drives results.valid. Reset
// clears the parse state, the configuration registers and both valid flags.
// A stalled result holds the step; chars.ready drops only when the input
// register is full and cannot drain into a busy result register.
module numeric_string_parser
    import nsp_pkg::*;
#(
    parameter int MAX_OFFSET = NSP_MAX_OFFSET,
    parameter int VALUE_BITS = NSP_VALUE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    nsp_char_if.sink      chars,
    nsp_result_if.source  results,
    nsp_cfg_if.sink       regs
);

    cfg_t    cfg;
    step_t   step;
    result_t res;

    // Input register
    logic              in_vld_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_start_reg;

    // Result register
    logic                out_vld_reg, out_vld_next;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    // The step runs when there is a character and room for a possible result
    assign step.go           = in_vld_reg && (!out_vld_reg || results.ready);
    assign step.char_code    = in_char_reg;
    assign step.string_start = in_start_reg;

    assign chars.ready = !in_vld_reg || step.go;

    nsp_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cfg   (cfg)
    );

    nsp_parse_core #(
        .MAX_OFFSET (MAX_OFFSET),
        .VALUE_BITS (VALUE_BITS)
    ) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (chars.ready)
            in_vld_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_char_reg  <= chars.char_code;
            in_start_reg <= chars.string_start;
        end
    end

    // Result register: a taken result clears unless a new one lands
    always_comb
    begin
        out_vld_next = out_vld_reg && !results.ready;
        if (res.emit)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            out_value_reg  <= res.value;
            out_offset_reg <= res.offset;
        end
    end

    assign results.valid        = out_vld_reg;
    assign results.parsed_value = out_value_reg;
    assign results.end_offset   = out_offset_reg;

endmodule

// ===== rtl/nsp_cfg_regs.sv =====
// Configuration registers: radix and signed mode.
module nsp_cfg_regs
    import nsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nsp_cfg_if.sink   regs,
    output cfg_t      cfg
);

    cfg_t cfg_reg;

    assign regs.ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (regs.valid)
        begin
            unique case (regs.index)
                CFG_NUMBER_BASE: cfg_reg.number_base <= regs.data[BASE_W-1:0];
                CFG_SIGNED_MODE: cfg_reg.signed_mode <= regs.data[0];
                default:         ;  // unmapped index, ignored
            endcase
        end
    end

endmodule

// ===== rtl/nsp_parse_core.sv =====
// Parse state and per-character step logic: prefix, sign and multiply-add.
module nsp_parse_core
    import nsp_pkg::*;
#(
    parameter int MAX_OFFSET = NSP_MAX_OFFSET,
    parameter int VALUE_BITS = NSP_VALUE_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  step_t   step,
    output result_t res
);

    localparam int POS_W = $clog2(MAX_OFFSET + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_OFFSET);

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  neg_reg, neg_next;

    logic                  done;
    logic                  adv;
    logic                  emit;
    logic [POS_W-1:0]      off;
    logic                  is_x;
    digit_t                dig;
    logic [VALUE_BITS-1:0] fin_value;

    assign is_x = (step.char_code == CH_UP_X) || (step.char_code == CH_LO_X);
    assign dig  = digit_decode(step.char_code);

    // Fall-through evaluation of the phase chain for one character
    always_comb
    begin
        acc_next   = acc_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        done       = 1'b0;
        adv        = 1'b0;
        emit       = 1'b0;
        off        = pos_reg;

        if (step.string_start)
        begin
            acc_next   = '0;
            base_next  = cfg.number_base;
            pos_next   = '0;
            neg_next   = 1'b0;
            phase_next = PH_SIGN;
        end

        if (phase_next == PH_IDLE)
            done = 1'b1;

        if (!done && phase_next == PH_SIGN)
        begin
            phase_next = PH_PREFIX;
            if (cfg.signed_mode && step.char_code == CH_MINUS)
            begin
                neg_next = 1'b1;
                adv      = 1'b1;
                done     = 1'b1;
            end
        end

        if (!done && phase_next == PH_PREFIX)
        begin
            if (base_next == BASE_AUTO)
            begin
                if (step.char_code == CH_ZERO)
                begin
                    base_next  = BASE_OCT;
                    phase_next = PH_ZAUTO;
                    adv        = 1'b1;
                    done       = 1'b1;
                end
                else
                    base_next = BASE_DEC;
            end
            else if (base_next == BASE_HEX && step.char_code == CH_ZERO)
            begin
                phase_next = PH_ZHEX;
                adv        = 1'b1;
                done       = 1'b1;
            end
            if (!done)
                phase_next = PH_DIGITS;
        end

        if (!done && phase_next == PH_ZAUTO)
        begin
            if (is_x)
            begin
                phase_next = PH_XPEND;
                adv        = 1'b1;
                done       = 1'b1;
            end
            else
                phase_next = PH_DIGITS;
        end

        if (!done && phase_next == PH_ZHEX)
        begin
            phase_next = PH_DIGITS;
            if (is_x)
            begin
                adv  = 1'b1;
                done = 1'b1;
            end
        end

        // "0x" with no hex digit after it: the x is left unconsumed
        if (!done && phase_next == PH_XPEND)
        begin
            if (!dig.hit)
            begin
                emit       = 1'b1;
                off        = pos_next - 1'b1;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else
            begin
                base_next  = BASE_HEX;
                phase_next = PH_DIGITS;
            end
        end

        if (!done)
        begin
            if (dig.hit && ({1'b0, dig.val} < base_next))
            begin
                acc_next = VALUE_BITS'(acc_next * VALUE_BITS'(base_next))
                         + VALUE_BITS'(dig.val);
                adv      = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                off        = pos_next;
                phase_next = PH_IDLE;
            end
        end

        if (adv && pos_next < POS_MAX)
            pos_next = pos_next + 1'b1;
    end

    assign fin_value = neg_next ? (VALUE_BITS'(0) - acc_next) : acc_next;

    always_comb
    begin
        res.emit   = step.go && emit;
        res.value  = VALUE_W'(64'(fin_value));
        res.offset = OFFSET_W'(16'(off));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            base_reg  <= '0;
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (step.go)
        begin
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            neg_reg   <= neg_next;
        end
    end

endmodule
